[rtl/core/rdmc_pkg.sv]
// shared types, codes and helpers for the replan decision and mode controller
package rdmc_pkg;

    // counter width for the failure and reversal counters
    localparam int COUNT_W = 8;

    // heading deadband half-width in microradians
    localparam int DEADBAND_URAD = 1000;

    // flag bit positions
    localparam int FLAG_HOLD       = 0;
    localparam int FLAG_VALID      = 1;
    localparam int FLAG_PREFIX_OK  = 2;
    localparam int FLAG_BLOCKED    = 3;
    localparam int FLAG_EXHAUSTING = 4;
    localparam int FLAG_SCORE      = 5;
    localparam int FLAG_GUIDE      = 6;

    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [1:0] {
        EV_DECIDE     = 2'd0,
        EV_RECOV_FAIL = 2'd1,
        EV_GUIDE_SET  = 2'd2,
        EV_GUIDE_CLR  = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        ACT_PUBLISH = 3'd0,
        ACT_KEEP    = 3'd1,
        ACT_RECOVER = 3'd2,
        ACT_HOLD    = 3'd3,
        ACT_STALE   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        PM_DIRECT   = 2'd0,
        PM_RECOVERY = 2'd1,
        PM_GUIDED   = 2'd2,
        PM_HOLD     = 2'd3
    } t_pmode;

    typedef enum logic [1:0] {
        SIGN_NONE = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } t_sign;

    typedef enum logic [1:0] {
        CFG_FAILURE_LIMIT    = 2'd0,
        CFG_PROGRESS_TIMEOUT = 2'd1,
        CFG_MIN_SCORE_GAIN   = 2'd2,
        CFG_SWITCH_LIMIT     = 2'd3
    } t_cfg_idx;

    // configuration register file contents
    typedef struct packed {
        logic [7:0]  failure_limit;
        logic [19:0] progress_timeout_ms;
        logic [30:0] min_score_gain;
        logic [7:0]  switch_limit;
    } t_cfg;

    // one input event
    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        gen_id;
        logic [31:0]        latest_gen_id;
        logic [31:0]        grid_rev;
        logic [31:0]        latest_grid_rev;
        logic [6:0]         flags;
        logic [19:0]        since_progress_ms;
        logic signed [22:0] heading_offset_urad;
        logic signed [31:0] active_score_val;
        logic signed [31:0] candidate_score_val;
        logic [31:0]        new_guide_rev;
    } t_in_item;

    // one result
    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  planner_mode;
        logic [7:0]  failure_count;
        logic        guide_present;
        logic [31:0] guide_rev_out;
    } t_out_item;

    // saturating increment at the all-ones value
    function automatic t_count count_sat_inc(input t_count c);
        t_count r;
        r = (c == {COUNT_W{1'b1}}) ? c : c + t_count'(1);
        return r;
    endfunction

    // clamp a counter onto the 8-bit result field
    function automatic logic [7:0] count_to_out(input t_count c);
        logic [31:0] w;
        w = 32'(c);
        return (w > 32'd255) ? 8'hFF : w[7:0];
    endfunction

endpackage

[rtl/core/rdmc_in_if.sv]
// input event channel
interface rdmc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [31:0]        gen_id;
    logic [31:0]        latest_gen_id;
    logic [31:0]        grid_rev;
    logic [31:0]        latest_grid_rev;
    logic [6:0]         flags;
    logic [19:0]        since_progress_ms;
    logic signed [22:0] heading_offset_urad;
    logic signed [31:0] active_score_val;
    logic signed [31:0] candidate_score_val;
    logic [31:0]        new_guide_rev;

    modport source (
        output valid, mode, gen_id, latest_gen_id, grid_rev, latest_grid_rev, flags,
               since_progress_ms, heading_offset_urad, active_score_val,
               candidate_score_val, new_guide_rev,
        input  ready
    );

    modport sink (
        input  valid, mode, gen_id, latest_gen_id, grid_rev, latest_grid_rev, flags,
               since_progress_ms, heading_offset_urad, active_score_val,
               candidate_score_val, new_guide_rev,
        output ready
    );
endinterface

[rtl/core/rdmc_out_if.sv]
// result channel
interface rdmc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [1:0]  planner_mode;
    logic [7:0]  failure_count;
    logic        guide_present;
    logic [31:0] guide_rev_out;

    modport source (
        output valid, action, planner_mode, failure_count, guide_present, guide_rev_out,
        input  ready
    );

    modport sink (
        input  valid, action, planner_mode, failure_count, guide_present, guide_rev_out,
        output ready
    );
endinterface

[rtl/core/replan_decision_mode_controller.sv]
// top level of the replan decision and mode controller
// Usage:
//   i_in carries one planner event per beat (decide, recovery failed, guide set,
//   guide cleared). o_out carries one result beat for each decide or
//   recovery-failed event; guide events update state and give no beat.
//   The configuration port writes a register at any edge with i_cfg_we high outside reset;
//   write only while no event is in flight.
// Path: an accepted event is held in the input register, decided there
//   against the controller state, and its result is loaded into the result
//   register that drives o_out once that register is free.
// Throughput: one event per cycle if o_out is ready; the decision is one pass
//   of compares and counter updates between the input and result registers.
// Stall: while o_out is stalled with a result waiting, the input register
//   still takes one more event, and i_in.ready drops until the result moves.
// Reset: i_rst_n low at an edge empties both registers, restores the
//   configuration defaults and clears mode, counters, direction and guide.
module replan_decision_mode_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rdmc_in_if.sink     i_in,
    rdmc_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);

    rdmc_pkg::t_cfg      cfg;
    rdmc_pkg::t_in_item  in_item;
    rdmc_pkg::t_in_item  r_s1_item;
    logic                r_s1_valid;
    rdmc_pkg::t_out_item core_result;
    rdmc_pkg::t_out_item r_out_item;
    logic                r_out_valid;
    logic                core_has_result;
    logic                out_free;
    logic                s1_fire;
    logic                in_beat;

    rdmc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // pack the incoming beat
    always_comb begin
        in_item.mode                = i_in.mode;
        in_item.gen_id              = i_in.gen_id;
        in_item.latest_gen_id       = i_in.latest_gen_id;
        in_item.grid_rev            = i_in.grid_rev;
        in_item.latest_grid_rev     = i_in.latest_grid_rev;
        in_item.flags               = i_in.flags;
        in_item.since_progress_ms   = i_in.since_progress_ms;
        in_item.heading_offset_urad = i_in.heading_offset_urad;
        in_item.active_score_val    = i_in.active_score_val;
        in_item.candidate_score_val = i_in.candidate_score_val;
        in_item.new_guide_rev       = i_in.new_guide_rev;
    end

    // handshake between the two register stages
    assign out_free    = !r_out_valid || o_out.ready;
    assign s1_fire     = r_s1_valid && out_free;
    assign i_in.ready  = !r_s1_valid || s1_fire;
    assign in_beat     = i_in.valid && i_in.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_item <= in_item;
        end
    end

    rdmc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (s1_fire),
        .i_item       (r_s1_item),
        .i_cfg        (cfg),
        .o_has_result (core_has_result),
        .o_result     (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= core_has_result;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && core_has_result) begin
            r_out_item <= core_result;
        end
    end

    // drive the result channel
    assign o_out.valid         = r_out_valid;
    assign o_out.action        = r_out_item.action;
    assign o_out.planner_mode  = r_out_item.planner_mode;
    assign o_out.failure_count = r_out_item.failure_count;
    assign o_out.guide_present = r_out_item.guide_present;
    assign o_out.guide_rev_out = r_out_item.guide_rev_out;

endmodule

[rtl/core/rdmc_cfg_regs.sv]
// configuration register file with write port
module rdmc_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [30:0]       i_cfg_data,
    output rdmc_pkg::t_cfg    o_cfg
);

    rdmc_pkg::t_cfg r_cfg;

    // register writes by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.failure_limit       <= 8'd3;
            r_cfg.progress_timeout_ms <= 20'd5000;
            r_cfg.min_score_gain      <= 31'd0;
            r_cfg.switch_limit        <= 8'd3;
        end else if (i_cfg_we) begin
            case (rdmc_pkg::t_cfg_idx'(i_cfg_idx))
                rdmc_pkg::CFG_FAILURE_LIMIT:    r_cfg.failure_limit       <= i_cfg_data[7:0];
                rdmc_pkg::CFG_PROGRESS_TIMEOUT: r_cfg.progress_timeout_ms <= i_cfg_data[19:0];
                rdmc_pkg::CFG_MIN_SCORE_GAIN:   r_cfg.min_score_gain      <= i_cfg_data;
                rdmc_pkg::CFG_SWITCH_LIMIT:     r_cfg.switch_limit        <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/rdmc_core.sv]
// controller state and single-pass decision logic
module rdmc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  rdmc_pkg::t_in_item  i_item,
    input  rdmc_pkg::t_cfg      i_cfg,
    output logic                o_has_result,
    output rdmc_pkg::t_out_item o_result
);

    rdmc_pkg::t_pmode  r_mode,   n_mode;
    rdmc_pkg::t_count  r_fail,   n_fail;
    rdmc_pkg::t_count  r_switch, n_switch;
    rdmc_pkg::t_sign   r_last_sign, n_last_sign;
    logic              r_gflag,  n_gflag;
    logic [31:0]       r_grev,   n_grev;
    rdmc_pkg::t_action act;

    logic              stale;
    logic              f_hold, f_valid, f_prefix, f_blocked, f_exhaust, f_score, f_guide;
    logic [7:0]        flim, slim;
    rdmc_pkg::t_count  fail_inc, switch_inc;
    rdmc_pkg::t_sign   sign;
    logic signed [33:0] cand_plus_gain, active_ext;
    logic              replace, better;

    // flag decode
    assign f_hold    = i_item.flags[rdmc_pkg::FLAG_HOLD];
    assign f_valid   = i_item.flags[rdmc_pkg::FLAG_VALID];
    assign f_prefix  = i_item.flags[rdmc_pkg::FLAG_PREFIX_OK];
    assign f_blocked = i_item.flags[rdmc_pkg::FLAG_BLOCKED];
    assign f_exhaust = i_item.flags[rdmc_pkg::FLAG_EXHAUSTING];
    assign f_score   = i_item.flags[rdmc_pkg::FLAG_SCORE];
    assign f_guide   = i_item.flags[rdmc_pkg::FLAG_GUIDE];

    // a zero limit behaves as one
    assign flim = (i_cfg.failure_limit == 8'd0) ? 8'd1 : i_cfg.failure_limit;
    assign slim = (i_cfg.switch_limit == 8'd0) ? 8'd1 : i_cfg.switch_limit;

    assign stale = (i_item.gen_id != i_item.latest_gen_id) ||
                   (i_item.grid_rev != i_item.latest_grid_rev);

    assign fail_inc   = rdmc_pkg::count_sat_inc(r_fail);
    assign switch_inc = rdmc_pkg::count_sat_inc(r_switch);

    // heading direction outside the deadband
    always_comb begin
        if (i_item.heading_offset_urad > 23'(rdmc_pkg::DEADBAND_URAD))
            sign = rdmc_pkg::SIGN_POS;
        else if (i_item.heading_offset_urad < -23'(rdmc_pkg::DEADBAND_URAD))
            sign = rdmc_pkg::SIGN_NEG;
        else
            sign = rdmc_pkg::SIGN_NONE;
    end

    // exact score compare, widened so the sum cannot wrap
    assign cand_plus_gain = 34'(i_item.candidate_score_val) +
                            $signed({3'b000, i_cfg.min_score_gain});
    assign active_ext     = 34'(i_item.active_score_val);
    assign better  = f_score && (cand_plus_gain < active_ext);
    assign replace = !f_prefix || f_blocked || f_exhaust || f_hold || !f_score;

    // next state and action per event kind
    always_comb begin
        n_mode      = r_mode;
        n_fail      = r_fail;
        n_switch    = r_switch;
        n_last_sign = r_last_sign;
        n_gflag     = r_gflag;
        n_grev      = r_grev;
        act         = rdmc_pkg::ACT_KEEP;
        o_has_result = 1'b0;
        case (rdmc_pkg::t_event'(i_item.mode))
            rdmc_pkg::EV_DECIDE: begin
                o_has_result = 1'b1;
                if (stale) begin
                    act = rdmc_pkg::ACT_STALE;
                end else if (f_hold && !r_gflag) begin
                    n_mode = rdmc_pkg::PM_RECOVERY;
                    act    = rdmc_pkg::ACT_RECOVER;
                end else if (!f_valid) begin
                    n_fail = fail_inc;
                    if ((32'(fail_inc) >= 32'(flim)) ||
                        (i_item.since_progress_ms >= i_cfg.progress_timeout_ms)) begin
                        n_mode = rdmc_pkg::PM_RECOVERY;
                        act    = rdmc_pkg::ACT_RECOVER;
                    end else begin
                        act = rdmc_pkg::ACT_KEEP;
                    end
                end else begin
                    n_fail = '0;
                    if (sign != rdmc_pkg::SIGN_NONE && r_last_sign != rdmc_pkg::SIGN_NONE &&
                        sign != r_last_sign)
                        n_switch = switch_inc;
                    if (sign != rdmc_pkg::SIGN_NONE)
                        n_last_sign = sign;
                    if (32'(n_switch) >= 32'(slim)) begin
                        n_switch = '0;
                        n_mode   = rdmc_pkg::PM_RECOVERY;
                        act      = rdmc_pkg::ACT_RECOVER;
                    end else begin
                        n_mode = r_gflag ? rdmc_pkg::PM_GUIDED : rdmc_pkg::PM_DIRECT;
                        act    = (replace || better) ? rdmc_pkg::ACT_PUBLISH
                                                     : rdmc_pkg::ACT_KEEP;
                    end
                end
            end
            rdmc_pkg::EV_RECOV_FAIL: begin
                o_has_result = 1'b1;
                n_mode = f_prefix ? rdmc_pkg::PM_RECOVERY : rdmc_pkg::PM_HOLD;
                act    = f_prefix ? rdmc_pkg::ACT_KEEP : rdmc_pkg::ACT_HOLD;
            end
            rdmc_pkg::EV_GUIDE_SET: begin
                n_grev  = i_item.new_guide_rev;
                n_gflag = f_guide;
            end
            rdmc_pkg::EV_GUIDE_CLR: begin
                n_gflag = 1'b0;
                if (r_mode == rdmc_pkg::PM_GUIDED)
                    n_mode = rdmc_pkg::PM_DIRECT;
            end
            default: ;
        endcase
    end

    // result reflects the state after this event
    always_comb begin
        o_result.action        = act;
        o_result.planner_mode  = n_mode;
        o_result.failure_count = rdmc_pkg::count_to_out(n_fail);
        o_result.guide_present = n_gflag;
        o_result.guide_rev_out = n_grev;
    end

    // state update when an event is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= rdmc_pkg::PM_DIRECT;
            r_fail      <= '0;
            r_switch    <= '0;
            r_last_sign <= rdmc_pkg::SIGN_NONE;
            r_gflag     <= 1'b0;
            r_grev      <= 32'd0;
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_fail      <= n_fail;
            r_switch    <= n_switch;
            r_last_sign <= n_last_sign;
            r_gflag     <= n_gflag;
            r_grev      <= n_grev;
        end
    end

endmodule
